// ===== rtl/clb_pkg.sv =====
package clb_pkg;

  localparam int CELLS     = 1024;
  localparam int CAPACITY  = 64;
  localparam int MAX_ATOMS = 65536;

  localparam int KIND_W   = 2;
  localparam int CELL_W   = 10;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 2;
  localparam int SERIAL_W = 16;
  localparam int VALUE_W  = 17;
  localparam int COUNT_W  = 7;
  localparam int ATOM_W   = 17;
  localparam int CFG_W    = 11;
  localparam int BKT_AW   = CELL_W + SLOT_W;

  localparam logic [CFG_W-1:0] CELLS_IN_USE_RST = CFG_W'(1024);

  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EXHAUST = 2'd3;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CALC,
    S_CLEAR,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic capture;
    logic calc;
    logic sweep;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic sweep_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== rtl/clb_ctrl.sv =====
module clb_ctrl import clb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_CALC;
      end
      S_CALC: begin
        state_nxt = sts.is_clear ? S_CLEAR : S_RESULT;
      end
      S_CLEAR: begin
        if (sts.sweep_last) state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_INIT:   cmd.sweep = 1'b1;
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_CALC:   cmd.calc = 1'b1;
      S_CLEAR:  cmd.sweep = 1'b1;
      S_RESULT: cmd.load = sts.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

// ===== rtl/clb_dpath.sv =====
module clb_dpath import clb_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ctrl_cmd_t                  cmd,
  output ctrl_sts_t                  sts,
  input  logic [CFG_W-1:0]           cells_in_use,
  input  logic [KIND_W-1:0]          in_kind,
  input  logic [CELL_W-1:0]          in_cell_index,
  input  logic [SLOT_W-1:0]          in_slot_index,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        out_status,
  output logic [SERIAL_W-1:0]        out_atom_serial,
  output logic signed [VALUE_W-1:0]  out_slot_value,
  output logic [COUNT_W-1:0]         out_cell_count
);

  logic [COUNT_W-1:0]  cnt_mem [CELLS];
  logic [SERIAL_W-1:0] bkt_mem [CELLS*CAPACITY];

  logic [KIND_W-1:0]   kind_r;
  logic [CELL_W-1:0]   cell_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [COUNT_W-1:0]  cnt_q_r;
  logic [SERIAL_W-1:0] bkt_q_r;
  logic [CELL_W-1:0]   sweep_ptr_r;
  logic [ATOM_W-1:0]   next_atom_r, next_atom_nxt;

  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [SERIAL_W-1:0] res_serial_r, res_serial_nxt;
  logic [COUNT_W-1:0]  res_count_r, res_count_nxt;
  logic                res_hit_r, res_hit_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [SERIAL_W-1:0] out_serial_r;
  logic [VALUE_W-1:0]  out_value_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic cell_ok, exhausted, store_en, bkt_rd_en;

  assign sts.is_clear   = (kind_r == KIND_CLEAR);
  assign sts.sweep_last = (sweep_ptr_r == CELL_W'(CELLS - 1));
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign cell_ok = ({1'b0, cell_r} < cells_in_use) &&
                   ({{(ATOM_W-CELL_W){1'b0}}, cell_r} < ATOM_W'(CELLS));
  assign exhausted = (next_atom_r >= ATOM_W'(MAX_ATOMS));
  assign bkt_rd_en = cmd.calc && (kind_r == KIND_READ);

  always_comb begin
    next_atom_nxt  = next_atom_r;
    res_status_nxt = ST_OK;
    res_serial_nxt = '0;
    res_count_nxt  = '0;
    res_hit_nxt    = 1'b0;
    store_en       = 1'b0;
    case (kind_r)
      KIND_CLEAR: next_atom_nxt = '0;
      KIND_INSERT: begin
        if (!cell_ok) begin
          res_status_nxt = ST_RANGE;
          if (!exhausted) begin
            res_serial_nxt = next_atom_r[SERIAL_W-1:0];
            next_atom_nxt  = next_atom_r + ATOM_W'(1);
          end
        end else if (exhausted) begin
          res_status_nxt = ST_EXHAUST;
          res_count_nxt  = cnt_q_r;
        end else begin
          res_serial_nxt = next_atom_r[SERIAL_W-1:0];
          next_atom_nxt  = next_atom_r + ATOM_W'(1);
          if (cnt_q_r >= COUNT_W'(CAPACITY)) begin
            res_status_nxt = ST_FULL;
            res_count_nxt  = cnt_q_r;
          end else begin
            store_en      = 1'b1;
            res_count_nxt = cnt_q_r + COUNT_W'(1);
          end
        end
      end
      KIND_READ: begin
        if (!cell_ok) begin
          res_status_nxt = ST_RANGE;
        end else begin
          res_count_nxt = cnt_q_r;
          res_hit_nxt   = ({1'b0, slot_r} < cnt_q_r);
        end
      end
      default: next_atom_nxt = next_atom_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_ptr_r <= '0;
      next_atom_r <= '0;
    end else begin
      if (cmd.sweep) begin
        sweep_ptr_r <= sts.sweep_last ? '0 : sweep_ptr_r + CELL_W'(1);
      end
      if (cmd.calc) begin
        next_atom_r <= next_atom_nxt;
      end
    end
  end

  // count store: one write port shared by the clearing sweep and inserts
  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      cnt_mem[sweep_ptr_r] <= '0;
    end else if (cmd.calc && store_en) begin
      cnt_mem[cell_r] <= res_count_nxt;
    end
    if (cmd.capture) begin
      cnt_q_r <= cnt_mem[in_cell_index];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc && store_en) begin
      bkt_mem[{cell_r, cnt_q_r[SLOT_W-1:0]}] <= next_atom_r[SERIAL_W-1:0];
    end
    if (bkt_rd_en) begin
      bkt_q_r <= bkt_mem[{cell_r, slot_r}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      cell_r <= in_cell_index;
      slot_r <= in_slot_index;
    end
    if (cmd.calc) begin
      res_status_r <= res_status_nxt;
      res_serial_r <= res_serial_nxt;
      res_count_r  <= res_count_nxt;
      res_hit_r    <= res_hit_nxt;
    end
  end

  // output beat register; the next item may start while this one waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status_r <= res_status_r;
      out_serial_r <= res_serial_r;
      out_count_r  <= res_count_r;
      out_value_r  <= res_hit_r ? {1'b0, bkt_q_r} : '1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_atom_serial = out_serial_r;
  assign out_slot_value  = $signed(out_value_r);
  assign out_cell_count  = out_count_r;

endmodule

// ===== rtl/cell_list_bucket_binning.sv =====
// A result beat passes through the capture, calculation and result-load states
// and can wait in the result state while the output stalls; a new item is taken
// only in the idle state. A clear item sweeps the count store one cell per cycle.
// Reset is synchronous, active low; after reset the same sweep runs before the
// first item is accepted. Configuration writes are taken throughout.
module cell_list_bucket_binning import clb_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [KIND_W-1:0]          in_kind,
  input  logic [CELL_W-1:0]          in_cell_index,
  input  logic [SLOT_W-1:0]          in_slot_index,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        out_status,
  output logic [SERIAL_W-1:0]        out_atom_serial,
  output logic signed [VALUE_W-1:0]  out_slot_value,
  output logic [COUNT_W-1:0]         out_cell_count,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [CFG_W-1:0] cells_in_use_r;
  logic             reg_sel;
  ctrl_cmd_t        cmd;
  ctrl_sts_t        sts;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);
  assign prdata  = reg_sel ? {{(32-CFG_W){1'b0}}, cells_in_use_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_in_use_r <= CELLS_IN_USE_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      cells_in_use_r <= pwdata[CFG_W-1:0];
    end
  end

  clb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  clb_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cells_in_use    (cells_in_use_r),
    .in_kind         (in_kind),
    .in_cell_index   (in_cell_index),
    .in_slot_index   (in_slot_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_atom_serial (out_atom_serial),
    .out_slot_value  (out_slot_value),
    .out_cell_count  (out_cell_count)
  );

endmodule
